// ----- src/free_list_allocator_assert.svh -----
// ----------------------------------------------------------------------------
// Free list allocator assertion macros
// Concurrent checks for the allocator RTL; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef FREE_LIST_ALLOCATOR_ASSERT_SVH
`define FREE_LIST_ALLOCATOR_ASSERT_SVH

`ifndef SYNTHESIS
// property must hold at every edge outside reset
`define FLA_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// condition must never be true outside reset
`define FLA_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define FLA_ASSERT(label, clk, rst, prop, msg)
`define FLA_ASSERT_NEVER(label, clk, rst, cond, msg)
`endif

`endif

// ----- src/fla_pkg.sv -----
// ----------------------------------------------------------------------------
// Free list allocator package
// Sizes, codes and word types shared by the allocator modules.
// ----------------------------------------------------------------------------
package fla_pkg;

   localparam int MAX_EXTENTS   = 32;
   localparam int MAX_BLOCKS    = 64;
   localparam int PAGE_BYTES    = 4096;
   localparam int HEADER_BYTES  = 8;
   localparam int MIN_REMAINDER = 24;
   localparam int ROUND_BYTES   = 8;
   localparam int MAX_PAGES     = 256;

   localparam int OFF_W    = 20;
   localparam int LEN_W    = 21;
   localparam int SIZE_W   = 21;
   localparam int NEED_W   = 22;
   localparam int PAGES_W  = 9;
   localparam int STYLE_W  = 2;

   localparam int EXT_IDX_W = $clog2(MAX_EXTENTS);
   localparam int EXT_CNT_W = $clog2(MAX_EXTENTS + 1);
   localparam int BLK_IDX_W = $clog2(MAX_BLOCKS);
   localparam int BLK_CNT_W = $clog2(MAX_BLOCKS + 1);

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   localparam logic [STYLE_W-1:0] FIT_NONE  = 2'd0;
   localparam logic [STYLE_W-1:0] FIT_BEST  = 2'd1;
   localparam logic [STYLE_W-1:0] FIT_WORST = 2'd2;
   localparam logic [STYLE_W-1:0] FIT_FIRST = 2'd3;

   localparam logic REG_REGION_PAGES = 1'b0;

   typedef enum logic [1:0] {
      ST_OK,
      ST_BAD_ARGS,
      ST_NO_SPACE,
      ST_BAD_PTR
   } status_type;

   typedef struct packed {
      logic                command;
      logic [SIZE_W-1:0]   request_size;
      logic [STYLE_W-1:0]  fit_style;
      logic [OFF_W-1:0]    block_offset;
   } req_type;

   typedef struct packed {
      status_type          status;
      logic [OFF_W-1:0]    result_offset;
   } rsp_type;

   typedef struct packed {
      logic [OFF_W-1:0]    start;
      logic [LEN_W-1:0]    len;
   } extent_type;

endpackage

// ----- src/fla_core.sv -----
// ----------------------------------------------------------------------------
// Free list allocator core
// Sequencer over the extent table and the used-block table memories.
// ----------------------------------------------------------------------------
`include "free_list_allocator_assert.svh"

module fla_core
   import fla_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic [PAGES_W-1:0]  region_pages,
   input  logic                in_valid,
   output logic                in_ready,
   input  req_type             in_req,
   output logic                out_valid,
   input  logic                out_take,
   output rsp_type             out_rsp
);

   typedef enum logic [3:0] {
      S_IDLE, S_SEED, S_START, S_CHK1, S_SCAN, S_SLOT, S_AUPD,
      S_USCAN, S_PSCAN, S_FMERGE, S_SHDN, S_SHUP, S_DONE
   } state_type;

   state_type              state_ff;
   logic                   seeded_ff;
   logic [EXT_CNT_W-1:0]   ext_count_ff;
   logic [MAX_BLOCKS-1:0]  used_valid_ff;

   logic                   cmd_ff;
   logic [STYLE_W-1:0]     style_ff;
   logic                   zero_req_ff;
   logic [NEED_W-1:0]      need_ff;
   logic [OFF_W-1:0]       hs_ff;
   logic                   off_small_ff;

   logic [EXT_CNT_W-1:0]   scan_ff;
   logic                   ext_rv_ff;
   logic [EXT_CNT_W-1:0]   ext_ri_ff;
   logic                   picked_ff;
   logic [EXT_CNT_W-1:0]   pick_idx_ff;
   extent_type             pick_ff;

   logic [BLK_CNT_W-1:0]   uscan_ff;
   logic                   used_rv_ff;
   logic [BLK_IDX_W-1:0]   used_ri_ff;
   logic [BLK_IDX_W-1:0]   slot_ff;
   logic [LEN_W-1:0]       ulen_ff;

   extent_type             prev_ff;
   logic                   have_prev_ff;
   extent_type             next_ff;
   logic                   have_next_ff;
   logic [EXT_CNT_W-1:0]   pos_ff;

   status_type             res_status_ff;
   logic [OFF_W-1:0]       res_off_ff;

   // memories
   extent_type             ext_mem [MAX_EXTENTS];
   extent_type             ext_rd_ff;
   extent_type             used_mem [MAX_BLOCKS];
   extent_type             used_rd_ff;

   logic                   ext_re, ext_we;
   logic [EXT_IDX_W-1:0]   ext_ra, ext_wa;
   extent_type             ext_wd;
   logic                   used_re, used_we;
   logic [BLK_IDX_W-1:0]   used_ra;
   extent_type             used_wd;

   // helpers
   logic [EXT_CNT_W-1:0]   scan_inc, scan_dec, ri_dec, ri_inc, pos_dec, pos_inc, pick_inc;
   logic [NEED_W-1:0]      rd_len_x, pick_len_x, rounded, need_in;
   logic                   take_pick, chk1_fail, exact, mp, mn, used_hit;
   logic [LEN_W:0]         prev_end, hs_end;
   logic [PAGES_W-1:0]     pages_c;
   logic [LEN_W-1:0]       seed_len;

   assign scan_inc   = scan_ff + EXT_CNT_W'(1);
   assign scan_dec   = scan_ff - EXT_CNT_W'(1);
   assign ri_dec     = ext_ri_ff - EXT_CNT_W'(1);
   assign ri_inc     = ext_ri_ff + EXT_CNT_W'(1);
   assign pos_dec    = pos_ff - EXT_CNT_W'(1);
   assign pos_inc    = pos_ff + EXT_CNT_W'(1);
   assign pick_inc   = pick_idx_ff + EXT_CNT_W'(1);

   assign rd_len_x   = NEED_W'(ext_rd_ff.len);
   assign pick_len_x = NEED_W'(pick_ff.len);
   assign take_pick  = (rd_len_x >= need_ff) &&
                       (!picked_ff ||
                        (style_ff == FIT_BEST  && ext_rd_ff.len < pick_ff.len) ||
                        (style_ff == FIT_WORST && ext_rd_ff.len > pick_ff.len));
   assign chk1_fail  = rd_len_x < (need_ff + NEED_W'(MIN_REMAINDER));
   assign exact      = pick_len_x == need_ff;

   assign prev_end   = (LEN_W+1)'(prev_ff.start) + (LEN_W+1)'(prev_ff.len);
   assign hs_end     = (LEN_W+1)'(hs_ff) + (LEN_W+1)'(ulen_ff);
   assign mp         = have_prev_ff && (prev_end == (LEN_W+1)'(hs_ff));
   assign mn         = have_next_ff && (hs_end == (LEN_W+1)'(next_ff.start));
   assign used_hit   = used_rv_ff && used_valid_ff[used_ri_ff] && (used_rd_ff.start == hs_ff);

   assign rounded    = (NEED_W'(in_req.request_size) + NEED_W'(ROUND_BYTES - 1)) &
                       ~NEED_W'(ROUND_BYTES - 1);
   assign need_in    = rounded + NEED_W'(HEADER_BYTES);

   always_comb begin
      if (region_pages == '0) begin
         pages_c = PAGES_W'(1);
      end else if (region_pages > PAGES_W'(MAX_PAGES)) begin
         pages_c = PAGES_W'(MAX_PAGES);
      end else begin
         pages_c = region_pages;
      end
   end
   assign seed_len = LEN_W'(pages_c) * LEN_W'(PAGE_BYTES);

   // memory port control
   always_comb begin
      ext_re  = 1'b0;
      ext_ra  = '0;
      ext_we  = 1'b0;
      ext_wa  = '0;
      ext_wd  = '0;
      used_re = 1'b0;
      used_ra = '0;
      used_we = 1'b0;
      used_wd = '0;
      unique case (state_ff)
         S_SEED: begin
            ext_we = 1'b1;
            ext_wd = '{start: '0, len: seed_len};
         end
         S_START: begin
            ext_re = (cmd_ff == CMD_ALLOC) && !zero_req_ff &&
                     (ext_count_ff == EXT_CNT_W'(1));
         end
         S_SCAN, S_PSCAN: begin
            ext_re = scan_ff < ext_count_ff;
            ext_ra = scan_ff[EXT_IDX_W-1:0];
         end
         S_AUPD: begin
            used_we = 1'b1;
            used_wd = '{start: pick_ff.start, len: need_ff[LEN_W-1:0]};
            if (!exact) begin
               ext_we = 1'b1;
               ext_wa = pick_idx_ff[EXT_IDX_W-1:0];
               ext_wd = '{start: pick_ff.start + need_ff[OFF_W-1:0],
                          len:   pick_ff.len - need_ff[LEN_W-1:0]};
            end
         end
         S_USCAN: begin
            used_re = uscan_ff < BLK_CNT_W'(MAX_BLOCKS);
            used_ra = uscan_ff[BLK_IDX_W-1:0];
         end
         S_FMERGE: begin
            if (mp && mn) begin
               ext_we = 1'b1;
               ext_wa = pos_dec[EXT_IDX_W-1:0];
               ext_wd = '{start: prev_ff.start, len: prev_ff.len + ulen_ff + next_ff.len};
            end else if (mp) begin
               ext_we = 1'b1;
               ext_wa = pos_dec[EXT_IDX_W-1:0];
               ext_wd = '{start: prev_ff.start, len: prev_ff.len + ulen_ff};
            end else if (mn) begin
               ext_we = 1'b1;
               ext_wa = pos_ff[EXT_IDX_W-1:0];
               ext_wd = '{start: hs_ff, len: next_ff.len + ulen_ff};
            end
         end
         S_SHDN: begin
            // entry i+1 moves to i
            ext_re = scan_ff < ext_count_ff;
            ext_ra = scan_ff[EXT_IDX_W-1:0];
            ext_we = ext_rv_ff;
            ext_wa = ri_dec[EXT_IDX_W-1:0];
            ext_wd = ext_rd_ff;
         end
         S_SHUP: begin
            // entry i-1 moves to i, then the new extent lands at pos
            ext_re = scan_ff > pos_ff;
            ext_ra = scan_dec[EXT_IDX_W-1:0];
            if (ext_rv_ff) begin
               ext_we = 1'b1;
               ext_wa = ri_inc[EXT_IDX_W-1:0];
               ext_wd = ext_rd_ff;
            end else if (!ext_re) begin
               ext_we = 1'b1;
               ext_wa = pos_ff[EXT_IDX_W-1:0];
               ext_wd = '{start: hs_ff, len: ulen_ff};
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (ext_we) begin
         ext_mem[ext_wa] <= ext_wd;
      end
      if (ext_re) begin
         ext_rd_ff <= ext_mem[ext_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (used_we) begin
         used_mem[slot_ff] <= used_wd;
      end
      if (used_re) begin
         used_rd_ff <= used_mem[used_ra];
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         seeded_ff     <= 1'b0;
         ext_count_ff  <= '0;
         used_valid_ff <= '0;
         ext_rv_ff     <= 1'b0;
         used_rv_ff    <= 1'b0;
         picked_ff     <= 1'b0;
         have_prev_ff  <= 1'b0;
         have_next_ff  <= 1'b0;
         res_status_ff <= ST_OK;
         res_off_ff    <= '0;
      end else begin
         ext_rv_ff  <= 1'b0;
         used_rv_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (in_valid) begin
                  cmd_ff       <= in_req.command;
                  style_ff     <= in_req.fit_style;
                  zero_req_ff  <= in_req.request_size == '0;
                  need_ff      <= need_in;
                  hs_ff        <= in_req.block_offset - OFF_W'(HEADER_BYTES);
                  off_small_ff <= in_req.block_offset < OFF_W'(HEADER_BYTES);
                  res_off_ff   <= '0;
                  state_ff     <= seeded_ff ? S_START : S_SEED;
               end
            end
            S_SEED: begin
               seeded_ff    <= 1'b1;
               ext_count_ff <= EXT_CNT_W'(1);
               state_ff     <= S_START;
            end
            S_START: begin
               scan_ff   <= '0;
               uscan_ff  <= '0;
               picked_ff <= 1'b0;
               if (cmd_ff == CMD_ALLOC) begin
                  if (zero_req_ff) begin
                     res_status_ff <= ST_BAD_ARGS;
                     state_ff      <= S_DONE;
                  end else if (ext_count_ff == EXT_CNT_W'(1)) begin
                     state_ff <= S_CHK1;
                  end else if (style_ff == FIT_NONE) begin
                     res_status_ff <= ST_BAD_ARGS;
                     state_ff      <= S_DONE;
                  end else begin
                     state_ff <= S_SCAN;
                  end
               end else if (off_small_ff) begin
                  res_status_ff <= ST_BAD_PTR;
                  state_ff      <= S_DONE;
               end else begin
                  state_ff <= S_USCAN;
               end
            end
            S_CHK1: begin
               if (chk1_fail) begin
                  res_status_ff <= ST_NO_SPACE;
                  state_ff      <= S_DONE;
               end else if (style_ff == FIT_NONE) begin
                  res_status_ff <= ST_BAD_ARGS;
                  state_ff      <= S_DONE;
               end else begin
                  state_ff <= S_SCAN;
               end
            end
            S_SCAN: begin
               if (ext_re) begin
                  scan_ff   <= scan_inc;
                  ext_rv_ff <= 1'b1;
                  ext_ri_ff <= scan_ff;
               end
               if (ext_rv_ff && take_pick) begin
                  picked_ff   <= 1'b1;
                  pick_idx_ff <= ext_ri_ff;
                  pick_ff     <= ext_rd_ff;
               end
               if (!ext_re && !ext_rv_ff) begin
                  slot_ff <= '0;
                  if (picked_ff) begin
                     state_ff <= S_SLOT;
                  end else begin
                     res_status_ff <= ST_NO_SPACE;
                     state_ff      <= S_DONE;
                  end
               end
            end
            S_SLOT: begin
               if (!used_valid_ff[slot_ff]) begin
                  state_ff <= S_AUPD;
               end else if (slot_ff == BLK_IDX_W'(MAX_BLOCKS - 1)) begin
                  res_status_ff <= ST_NO_SPACE;
                  state_ff      <= S_DONE;
               end else begin
                  slot_ff <= slot_ff + BLK_IDX_W'(1);
               end
            end
            S_AUPD: begin
               used_valid_ff[slot_ff] <= 1'b1;
               res_status_ff          <= ST_OK;
               res_off_ff             <= pick_ff.start + OFF_W'(HEADER_BYTES);
               if (exact) begin
                  scan_ff  <= pick_inc;
                  state_ff <= S_SHDN;
               end else begin
                  state_ff <= S_DONE;
               end
            end
            S_USCAN: begin
               if (used_re) begin
                  uscan_ff   <= uscan_ff + BLK_CNT_W'(1);
                  used_rv_ff <= 1'b1;
                  used_ri_ff <= uscan_ff[BLK_IDX_W-1:0];
               end
               if (used_hit) begin
                  slot_ff      <= used_ri_ff;
                  ulen_ff      <= used_rd_ff.len;
                  have_prev_ff <= 1'b0;
                  have_next_ff <= 1'b0;
                  state_ff     <= S_PSCAN;
               end else if (!used_re && !used_rv_ff) begin
                  res_status_ff <= ST_BAD_PTR;
                  state_ff      <= S_DONE;
               end
            end
            S_PSCAN: begin
               if (ext_re) begin
                  scan_ff   <= scan_inc;
                  ext_rv_ff <= 1'b1;
                  ext_ri_ff <= scan_ff;
               end
               if (ext_rv_ff) begin
                  if (ext_rd_ff.start > hs_ff) begin
                     pos_ff       <= ext_ri_ff;
                     next_ff      <= ext_rd_ff;
                     have_next_ff <= 1'b1;
                     state_ff     <= S_FMERGE;
                  end else begin
                     prev_ff      <= ext_rd_ff;
                     have_prev_ff <= 1'b1;
                  end
               end else if (!ext_re) begin
                  pos_ff   <= ext_count_ff;
                  state_ff <= S_FMERGE;
               end
            end
            S_FMERGE: begin
               res_status_ff <= ST_OK;
               if (mp && mn) begin
                  used_valid_ff[slot_ff] <= 1'b0;
                  scan_ff                <= pos_inc;
                  state_ff               <= S_SHDN;
               end else if (mp || mn) begin
                  used_valid_ff[slot_ff] <= 1'b0;
                  state_ff               <= S_DONE;
               end else if (ext_count_ff >= EXT_CNT_W'(MAX_EXTENTS)) begin
                  res_status_ff <= ST_NO_SPACE;
                  state_ff      <= S_DONE;
               end else begin
                  scan_ff  <= ext_count_ff;
                  state_ff <= S_SHUP;
               end
            end
            S_SHDN: begin
               if (ext_re) begin
                  scan_ff   <= scan_inc;
                  ext_rv_ff <= 1'b1;
                  ext_ri_ff <= scan_ff;
               end
               if (!ext_re && !ext_rv_ff) begin
                  ext_count_ff <= ext_count_ff - EXT_CNT_W'(1);
                  state_ff     <= S_DONE;
               end
            end
            S_SHUP: begin
               if (ext_re) begin
                  scan_ff   <= scan_dec;
                  ext_rv_ff <= 1'b1;
                  ext_ri_ff <= scan_dec;
               end
               if (!ext_re && !ext_rv_ff) begin
                  ext_count_ff           <= ext_count_ff + EXT_CNT_W'(1);
                  used_valid_ff[slot_ff] <= 1'b0;
                  state_ff               <= S_DONE;
               end
            end
            S_DONE: begin
               if (out_take) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign in_ready  = state_ff == S_IDLE;
   assign out_valid = state_ff == S_DONE;
   assign out_rsp   = '{status: res_status_ff, result_offset: res_off_ff};

   `FLA_ASSERT(a_count_max, clock, reset, ext_count_ff <= EXT_CNT_W'(MAX_EXTENTS), "extent count overflow")
   `FLA_ASSERT(a_seeded_nonempty, clock, reset, seeded_ff |-> (ext_count_ff != '0), "extent table emptied")
   `FLA_ASSERT(a_err_zero_off, clock, reset, (out_valid && res_status_ff != ST_OK) |-> (res_off_ff == '0), "error with offset")
   `FLA_ASSERT(a_done_holds, clock, reset, (out_valid && !out_take) |=> (out_valid && $stable(res_off_ff)), "result dropped")
   `FLA_ASSERT_NEVER(a_rw_same_entry, clock, reset, ext_we && ext_re && (ext_wa == ext_ra), "extent read and write collide")

endmodule

// ----- src/free_list_allocator.sv -----
// ----------------------------------------------------------------------------
// Free list allocator
// Address-sorted free extent table with best, worst and first fit allocation.
// ----------------------------------------------------------------------------
// Flow: an allocation scans the extent table, then searches the used table for a
//   free slot, with an extra check first for a lone extent and a seeding step on the
//   first word, and shifts the extent table down when an extent is used up; a free
//   searches the used table, finds the extent position, then merges or shifts.
// Throughput: one word at a time; the single-port read of each table memory
//   walks one entry per cycle, which sets the item time.
// Reset: synchronous; tables empty, region_pages back to 16, seeding on first word.

module free_list_allocator
   import fla_pkg::*;
(
   input  logic         clock,
   input  logic         reset,

   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [47:0]  req_tdata,   // request_size[20:0], fit_style[22:21], block_offset[42:23]
   input  logic         req_tuser,   // command

   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [23:0]  rsp_tdata,   // result_offset[19:0]
   output logic [1:0]   rsp_tuser,   // status

   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   logic [PAGES_W-1:0]  region_pages_ff;
   logic                rsp_valid_ff;
   rsp_type             rsp_ff;

   req_type             core_req;
   rsp_type             core_rsp;
   logic                core_valid;
   logic                out_take;

   // config register, written on the APB access phase
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         region_pages_ff <= PAGES_W'(16);
      end else if (csr_psel && csr_penable && csr_pwrite &&
                   csr_paddr[2] == REG_REGION_PAGES) begin
         region_pages_ff <= csr_pwdata[PAGES_W-1:0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == REG_REGION_PAGES) ? 32'(region_pages_ff) : '0;

   // unpack the incoming word
   assign core_req = '{command:      req_tuser,
                       request_size: req_tdata[20:0],
                       fit_style:    req_tdata[22:21],
                       block_offset: req_tdata[42:23]};

   // output register: the core can start the next word while this one waits
   assign out_take = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_take) begin
         rsp_valid_ff <= core_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_take && core_valid) begin
         rsp_ff <= core_rsp;
      end
   end

   fla_core u_core (
      .clock        (clock),
      .reset        (reset),
      .region_pages (region_pages_ff),
      .in_valid     (req_tvalid),
      .in_ready     (req_tready),
      .in_req       (core_req),
      .out_valid    (core_valid),
      .out_take     (out_take),
      .out_rsp      (core_rsp)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0, rsp_ff.result_offset};
   assign rsp_tuser  = rsp_ff.status;

endmodule
